// ----- hw/rtl/pre_pkg.sv -----
`default_nettype none
package pre_pkg;
   localparam int MAX_ITEMS = 1024;
   localparam int ID_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = ID_W + 1;

   typedef struct packed {
      logic [ID_W-1:0] item_index;
      logic            last_of_pivot;
   } pre_req_type;

   typedef struct packed {
      logic [ID_W-1:0]  item_class;
      logic [CNT_W-1:0] class_total;
      logic             index_error;
      logic             duplicate;
      logic             refine_done;
   } pre_rsp_type;
endpackage
`default_nettype wire

// ----- hw/rtl/pre_ram.sv -----
`default_nettype none
// One write port, one read port, registered read data.
module pre_ram #(
   parameter int DATA_W = 10,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] wa,
   input  wire logic [DATA_W-1:0] wd,
   input  wire logic [ADDR_W-1:0] ra,
   output logic      [DATA_W-1:0] rd
);
   logic [DATA_W-1:0] mem [(1 << ADDR_W)];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd <= mem[ra];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/partition_refinement_engine.sv -----
`default_nettype none
// Partition refinement engine. Pulse start with a request (one pivot index
// and a last-of-pivot flag) while busy is low; exactly one response follows
// on rsp_data, marked by a one-cycle rsp_valid strobe that the receiver must
// take, since it cannot stall the block. An ordinary index passes through
// class lookup, per-class table reads, update and target count update
// before the strobe. A duplicate index, or one held in place because no
// free id is left, skips the target count update. An out-of-range index
// responds in the cycle after start, with no table step. A request
// carrying last_of_pivot then walks the split list, with a read, a target
// fetch and a write-back per split class, before responding. Busy drops
// in the response cycle, so the next request can be taken there. Every
// table lives in its own single-port-read RAM, so these reads are
// serialized. After reset and after each write of item_count the block
// runs a clearing pass with busy high.
module partition_refinement_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire pre_pkg::pre_req_type  req_data,
   output logic                       busy,
   output logic                       rsp_valid,
   output pre_pkg::pre_rsp_type       rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [pre_pkg::CNT_W-1:0] csr_wdata
);
   localparam int IW = pre_pkg::ID_W;
   localparam int CW = pre_pkg::CNT_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CLR  = 3'd1;
   localparam logic [2:0] ST_RDC  = 3'd2;
   localparam logic [2:0] ST_DEC  = 3'd3;
   localparam logic [2:0] ST_INC  = 3'd4;
   localparam logic [2:0] ST_FRD  = 3'd5;
   localparam logic [2:0] ST_FTG  = 3'd6;
   localparam logic [2:0] ST_FWR  = 3'd7;

   localparam logic [CW-1:0] MAX_CNT = CW'(pre_pkg::MAX_ITEMS);
   localparam logic [IW-1:0] LAST_ID = IW'(pre_pkg::MAX_ITEMS - 1);

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          last_ff, last_in;
   logic [IW-1:0] c_ff, c_in;
   logic [IW-1:0] t_ff, t_in;
   logic [IW-1:0] s_ff, s_in;
   logic          new_ff, new_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] live_ff, live_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] cls_ff, cls_in;
   logic          err_ff, err_in;
   logic          dup_ff, dup_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // RAM ports
   logic          cls_we, mem_we, tgt_we, mrk_we, crt_we, lst_we, fre_we;
   logic [IW-1:0] cls_wa, mem_wa, tgt_wa, mrk_wa, crt_wa, lst_wa, fre_wa;
   logic [IW-1:0] cls_wd, tgt_wd, lst_wd, fre_wd;
   logic [CW-1:0] mem_wd;
   logic          mrk_wd, crt_wd;
   logic [IW-1:0] cls_ra, mem_ra, tgt_ra, mrk_ra, crt_ra, lst_ra, fre_ra;
   logic [IW-1:0] cls_rd, tgt_rd, lst_rd, fre_rd;
   logic [CW-1:0] mem_rd;
   logic          mrk_rd, crt_rd;

   logic [CW-1:0] csr_sat;
   logic [CW-1:0] mc_dec, live_up, base_cnt;
   logic [IW-1:0] t_sel;

   pre_ram #(.DATA_W(IW), .ADDR_W(IW)) u_class (
      .clock(clock), .we(cls_we), .wa(cls_wa), .wd(cls_wd), .ra(cls_ra), .rd(cls_rd));
   pre_ram #(.DATA_W(CW), .ADDR_W(IW)) u_members (
      .clock(clock), .we(mem_we), .wa(mem_wa), .wd(mem_wd), .ra(mem_ra), .rd(mem_rd));
   pre_ram #(.DATA_W(IW), .ADDR_W(IW)) u_target (
      .clock(clock), .we(tgt_we), .wa(tgt_wa), .wd(tgt_wd), .ra(tgt_ra), .rd(tgt_rd));
   pre_ram #(.DATA_W(1), .ADDR_W(IW)) u_marked (
      .clock(clock), .we(mrk_we), .wa(mrk_wa), .wd(mrk_wd), .ra(mrk_ra), .rd(mrk_rd));
   pre_ram #(.DATA_W(1), .ADDR_W(IW)) u_created (
      .clock(clock), .we(crt_we), .wa(crt_wa), .wd(crt_wd), .ra(crt_ra), .rd(crt_rd));
   pre_ram #(.DATA_W(IW), .ADDR_W(IW)) u_list (
      .clock(clock), .we(lst_we), .wa(lst_wa), .wd(lst_wd), .ra(lst_ra), .rd(lst_rd));
   pre_ram #(.DATA_W(IW), .ADDR_W(IW)) u_free (
      .clock(clock), .we(fre_we), .wa(fre_wa), .wd(fre_wd), .ra(fre_ra), .rd(fre_rd));

   // Saturate the written item count into 1..MAX_ITEMS.
   always_comb begin
      csr_sat = csr_wdata;
      if (csr_wdata == '0) begin
         csr_sat = CW'(1);
      end else if (csr_wdata > MAX_CNT) begin
         csr_sat = MAX_CNT;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      c_in         = c_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      new_in       = new_ff;
      k_in         = k_ff;
      len_in       = len_ff;
      top_in       = top_ff;
      live_in      = live_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      cls_in       = cls_ff;
      err_in       = err_ff;
      dup_in       = dup_ff;
      rsp_valid_in = 1'b0;

      cls_we = 1'b0; cls_wa = idx_ff; cls_wd = '0; cls_ra = req_data.item_index;
      mem_we = 1'b0; mem_wa = c_ff;   mem_wd = '0; mem_ra = cls_rd;
      tgt_we = 1'b0; tgt_wa = c_ff;   tgt_wd = '0; tgt_ra = cls_rd;
      mrk_we = 1'b0; mrk_wa = c_ff;   mrk_wd = 1'b0; mrk_ra = cls_rd;
      crt_we = 1'b0; crt_wa = c_ff;   crt_wd = 1'b0; crt_ra = cls_rd;
      lst_we = 1'b0; lst_wa = len_ff[IW-1:0]; lst_wd = c_ff; lst_ra = k_ff[IW-1:0];
      fre_we = 1'b0; fre_wa = top_ff[IW-1:0]; fre_wd = s_ff;
      fre_ra = IW'(top_ff - CW'(1));

      t_sel    = mrk_rd ? tgt_rd : fre_rd;
      mc_dec   = (mem_rd != '0) ? mem_rd - CW'(1) : '0;
      live_up  = mrk_rd ? live_ff : live_ff + CW'(1);
      base_cnt = new_ff ? '0 : mem_rd;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in  = req_data.item_index;
               last_in = req_data.last_of_pivot;
               dup_in  = 1'b0;
               cls_in  = '0;
               if ({1'b0, req_data.item_index} >= cnt_ff) begin
                  // out of range: no table change, cleanup still runs on last
                  err_in = 1'b1;
                  if (req_data.last_of_pivot) begin
                     k_in     = '0;
                     state_in = ST_FRD;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_RDC;
               end
            end
         end
         ST_CLR: begin
            // sweep every entry back to the single-class state
            cls_we = 1'b1; cls_wa = clr_ff; cls_wd = '0;
            mem_we = 1'b1; mem_wa = clr_ff; mem_wd = (clr_ff == '0) ? cnt_ff : '0;
            mrk_we = 1'b1; mrk_wa = clr_ff; mrk_wd = 1'b0;
            crt_we = 1'b1; crt_wa = clr_ff; crt_wd = 1'b0;
            fre_we = 1'b1; fre_wa = clr_ff; fre_wd = LAST_ID - clr_ff;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == LAST_ID) begin
               state_in = ST_IDLE;
            end
         end
         ST_RDC: begin
            // class is out; fetch its per-class entries and the free-stack top
            c_in     = cls_rd;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (crt_rd) begin
               dup_in = 1'b1;
               cls_in = c_ff;
               if (last_ff) begin
                  k_in = '0; state_in = ST_FRD;
               end else begin
                  rsp_valid_in = 1'b1; state_in = ST_IDLE;
               end
            end else if (!mrk_rd && (top_ff == '0 || len_ff[CW-1])) begin
               // no free id: hold the item in place
               cls_in = c_ff;
               if (last_ff) begin
                  k_in = '0; state_in = ST_FRD;
               end else begin
                  rsp_valid_in = 1'b1; state_in = ST_IDLE;
               end
            end else begin
               if (!mrk_rd) begin
                  tgt_we = 1'b1; tgt_wa = c_ff; tgt_wd = t_sel;
                  mrk_we = 1'b1; mrk_wa = c_ff; mrk_wd = 1'b1;
                  crt_we = 1'b1; crt_wa = t_sel; crt_wd = 1'b1;
                  lst_we = 1'b1;
                  len_in = len_ff + CW'(1);
                  top_in = top_ff - CW'(1);
               end
               mem_we = 1'b1; mem_wa = c_ff; mem_wd = mc_dec;
               live_in = (mc_dec == '0 && live_up != '0) ? live_up - CW'(1) : live_up;
               cls_we = 1'b1; cls_wa = idx_ff; cls_wd = t_sel;
               mem_ra   = t_sel;
               t_in     = t_sel;
               new_in   = !mrk_rd;
               state_in = ST_INC;
            end
         end
         ST_INC: begin
            mem_we = 1'b1; mem_wa = t_ff; mem_wd = base_cnt + CW'(1);
            cls_in = t_ff;
            if (last_ff) begin
               k_in = '0; state_in = ST_FRD;
            end else begin
               rsp_valid_in = 1'b1; state_in = ST_IDLE;
            end
         end
         ST_FRD: begin
            if (k_ff == len_ff) begin
               len_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_FTG;
            end
         end
         ST_FTG: begin
            s_in     = lst_rd;
            tgt_ra   = lst_rd;
            mem_ra   = lst_rd;
            state_in = ST_FWR;
         end
         ST_FWR: begin
            // unmark the split class, release its target, free it if empty
            mrk_we = 1'b1; mrk_wa = s_ff;   mrk_wd = 1'b0;
            crt_we = 1'b1; crt_wa = tgt_rd; crt_wd = 1'b0;
            if (mem_rd == '0 && !top_ff[CW-1]) begin
               fre_we = 1'b1;
               top_in = top_ff + CW'(1);
            end
            k_in     = k_ff + CW'(1);
            state_in = ST_FRD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         cnt_in   = csr_sat;
         clr_in   = '0;
         top_in   = CW'(pre_pkg::MAX_ITEMS - 1);
         len_in   = '0;
         live_in  = CW'(1);
         state_in = ST_CLR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         cnt_ff       <= MAX_CNT;
         top_ff       <= CW'(pre_pkg::MAX_ITEMS - 1);
         len_ff       <= '0;
         live_ff      <= CW'(1);
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         len_ff       <= len_in;
         live_ff      <= live_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      last_ff <= last_in;
      c_ff    <= c_in;
      t_ff    <= t_in;
      s_ff    <= s_in;
      new_ff  <= new_in;
      cls_ff  <= cls_in;
      err_ff  <= err_in;
      dup_ff  <= dup_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.item_class  = cls_ff;
   assign rsp_data.class_total = live_ff;
   assign rsp_data.index_error = err_ff;
   assign rsp_data.duplicate   = dup_ff;
   assign rsp_data.refine_done = last_ff;
endmodule
`default_nettype wire
